### design/rfd_pkg.sv
package rfd_pkg;

   // Fixed widths of the item fields.
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 9;
   localparam int TICK_W   = 16;
   localparam int EXP_W    = 9;
   localparam int CMP_W    = 10;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Line codes.
   localparam logic [BYTE_W-1:0] BYTE_START_LONG  = 8'hFD;
   localparam logic [BYTE_W-1:0] BYTE_START_SHORT = 8'hFE;
   localparam logic [BYTE_W-1:0] BYTE_ESCAPE      = 8'hFC;
   localparam logic [BYTE_W-1:0] BYTE_ACK         = 8'hF8;

   // Header layout.
   localparam logic [POS_W-1:0] HDR_CTRL_POS      = 9'd5;
   localparam logic [POS_W-1:0] HDR_SHORT_LEN_POS = 9'd6;
   localparam logic [POS_W-1:0] HDR_LONG_LEN_POS  = 9'd10;
   localparam logic [POS_W-1:0] HDR_FE_LEN_POS    = 9'd3;
   localparam logic [EXP_W-1:0] SHORT_LEN_BIAS    = 9'd7;
   localparam logic [EXP_W-1:0] LONG_LEN_BIAS     = 9'd11;

   // Register reset value.
   localparam logic [TICK_W-1:0] GAP_TIMEOUT_RESET = 16'd7;

   // Input command codes.
   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // Class of a queued item.
   typedef enum logic [1:0] {
      ITEM_TICK   = 2'd0,
      ITEM_ESCAPE = 2'd1,
      ITEM_START  = 2'd2,
      ITEM_PLAIN  = 2'd3
   } item_kind_type;

   // Class of the first byte of a frame.
   typedef enum logic [1:0] {
      START_OTHER = 2'd0,
      START_LONG  = 2'd1,
      START_SHORT = 2'd2,
      START_ACK   = 2'd3
   } start_kind_type;

   typedef enum logic {
      RESULT_DATA = 1'b0,
      RESULT_END  = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      STATUS_LENGTH    = 2'd0,
      STATUS_ACK       = 2'd1,
      STATUS_COLLISION = 2'd2,
      STATUS_GAP       = 2'd3
   } frame_status_type;

   // One classified item as it travels through the queue.
   typedef struct packed {
      item_kind_type       kind;
      logic [BYTE_W-1:0]   data;
      logic                tx;
      start_kind_type      plain_code;
      start_kind_type      escaped_code;
   } entry_type;

   // One result item.
   typedef struct packed {
      result_kind_type     kind;
      logic [BYTE_W-1:0]   data;
      logic [POS_W-1:0]    position;
      frame_status_type    status;
      logic                echo;
      logic                last;
   } result_type;

   // Start class of a byte as it would be delivered.
   function automatic start_kind_type start_code(input logic [BYTE_W-1:0] b);
      start_kind_type code;
      priority if (b == BYTE_START_LONG) begin
         code = START_LONG;
      end else if (b == BYTE_START_SHORT) begin
         code = START_SHORT;
      end else if (b == BYTE_ACK) begin
         code = START_ACK;
      end else begin
         code = START_OTHER;
      end
      return code;
   endfunction

   // The short header carries its length in byte 6.
   function automatic logic is_short_form(input logic [BYTE_W-1:0] ctrl);
      return (ctrl[1:0] == 2'b11) || !ctrl[3];
   endfunction

   function automatic result_type make_end(input frame_status_type status,
                                           input logic echo);
      result_type r;
      r.kind     = RESULT_END;
      r.data     = '0;
      r.position = '0;
      r.status   = status;
      r.echo     = echo;
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic result_type make_data(input logic [BYTE_W-1:0] d,
                                            input logic [POS_W-1:0] pos,
                                            input logic echo);
      result_type r;
      r.kind     = RESULT_DATA;
      r.data     = d;
      r.position = pos;
      r.status   = STATUS_LENGTH;
      r.echo     = echo;
      r.last     = 1'b0;
      return r;
   endfunction

endpackage

### design/rfd_front.sv
module rfd_front (
   input  logic                        req_cmd,
   input  logic [rfd_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic                        req_own_transmit,
   output rfd_pkg::entry_type          entry
);

   logic [rfd_pkg::BYTE_W-1:0] escaped_byte;

   // An escaped byte is delivered with its top bit set.
   assign escaped_byte = {1'b1, req_rx_byte[rfd_pkg::BYTE_W-2:0]};

   // Sort the item into tick, escape, start byte or ordinary byte, and
   // work out the start class of both forms the byte may take.
   always_comb begin
      entry.data         = req_rx_byte;
      entry.tx           = req_own_transmit;
      entry.plain_code   = rfd_pkg::start_code(req_rx_byte);
      entry.escaped_code = rfd_pkg::start_code(escaped_byte);
      priority if (req_cmd == rfd_pkg::CMD_TICK) begin
         entry.kind = rfd_pkg::ITEM_TICK;
      end else if (req_rx_byte == rfd_pkg::BYTE_ESCAPE) begin
         entry.kind = rfd_pkg::ITEM_ESCAPE;
      end else if (req_rx_byte == rfd_pkg::BYTE_START_LONG ||
                   req_rx_byte == rfd_pkg::BYTE_START_SHORT) begin
         entry.kind = rfd_pkg::ITEM_START;
      end else begin
         entry.kind = rfd_pkg::ITEM_PLAIN;
      end
   end

endmodule

### design/rfd_queue.sv
module rfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  rfd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output rfd_pkg::entry_type  pop_entry
);

   localparam int PTR_W = (rfd_pkg::QUEUE_DEPTH > 1) ? $clog2(rfd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(rfd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rfd_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(rfd_pkg::QUEUE_DEPTH);

   rfd_pkg::entry_type  store_ff [rfd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = store_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/rfd_back.sv
module rfd_back #(
   parameter int MAX_FRAME_BYTES = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  rfd_pkg::entry_type          q_entry,
   output logic                        q_pop,
   input  logic [rfd_pkg::TICK_W-1:0]  gap_timeout,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rfd_pkg::result_type         rsp_result
);

   localparam int CW = $clog2(MAX_FRAME_BYTES);
   localparam logic [CW:0] MAX_COUNT = (CW + 1)'(MAX_FRAME_BYTES);

   // Frame state.
   logic                            in_frame_ff, in_frame_in;
   logic                            esc_ff, esc_in;
   logic [CW-1:0]                   count_ff, count_in;
   rfd_pkg::start_kind_type         start_ff, start_in;
   logic                            short_ff, short_in;
   logic [rfd_pkg::EXP_W-1:0]       exp_ff, exp_in;
   logic                            lk_ff, lk_in;
   logic [rfd_pkg::TICK_W-1:0]      gap_ff, gap_in;
   logic                            echo_ff, echo_in;

   // Two result slots: slot a drives the port, slot b holds a second result.
   logic                            av_ff, av_in;
   logic                            bv_ff, bv_in;
   rfd_pkg::result_type             a_ff, a_in;
   rfd_pkg::result_type             b_ff, b_in;

   // Work signals of one item.
   rfd_pkg::result_type             r0, r1;
   logic [1:0]                      nres;
   logic                            taken;
   logic                            can_pop;
   logic                            clear;
   logic                            collision;
   logic                            do_push;
   logic [rfd_pkg::BYTE_W-1:0]      push_d;
   rfd_pkg::start_kind_type         push_code;
   logic [CW-1:0]                   pos;
   logic [rfd_pkg::POS_W-1:0]       pos9;
   logic [CW:0]                     cnt1;
   logic                            check_short;
   logic                            end_now;
   rfd_pkg::frame_status_type       end_status;
   logic [rfd_pkg::TICK_W-1:0]      gap_next;

   assign taken      = av_ff && !rsp_stall;
   assign can_pop    = !bv_ff && (!av_ff || taken);
   assign q_pop      = q_valid && can_pop;
   assign rsp_valid  = av_ff;
   assign rsp_result = a_ff;
   assign gap_next   = (gap_ff == '1) ? gap_ff : gap_ff + 1'b1;
   assign collision  = (q_entry.kind == rfd_pkg::ITEM_START) && (count_ff != '0);

   // Carry out one queued item: update the frame state and build its results.
   always_comb begin
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      count_in    = count_ff;
      start_in    = start_ff;
      short_in    = short_ff;
      exp_in      = exp_ff;
      lk_in       = lk_ff;
      gap_in      = gap_ff;
      echo_in     = echo_ff;
      r0          = '0;
      r1          = '0;
      nres        = 2'd0;
      clear       = 1'b0;
      do_push     = 1'b0;
      push_d      = q_entry.data;
      push_code   = q_entry.plain_code;
      pos         = '0;
      pos9        = '0;
      cnt1        = '0;
      check_short = 1'b0;
      end_now     = 1'b0;
      end_status  = rfd_pkg::STATUS_LENGTH;

      if (q_pop) begin
         if (q_entry.kind == rfd_pkg::ITEM_TICK) begin
            // Timer tick: only an open frame counts the gap.
            if (in_frame_ff) begin
               gap_in = gap_next;
               if (gap_next >= gap_timeout) begin
                  if (count_ff != '0) begin
                     r0   = rfd_pkg::make_end(rfd_pkg::STATUS_GAP, echo_ff);
                     nres = 2'd1;
                  end
                  clear = 1'b1;
               end
            end
         end else begin
            gap_in = '0;
            if (collision) begin
               // The old frame ends, the start byte opens a fresh one.
               r0          = rfd_pkg::make_end(rfd_pkg::STATUS_COLLISION,
                                               echo_ff | q_entry.tx);
               nres        = 2'd1;
               in_frame_in = 1'b1;
               esc_in      = 1'b0;
               count_in    = '0;
               start_in    = rfd_pkg::START_OTHER;
               short_in    = 1'b1;
               exp_in      = '0;
               lk_in       = 1'b0;
               echo_in     = 1'b0;
               do_push     = 1'b1;
            end else begin
               in_frame_in = 1'b1;
               echo_in     = echo_ff | q_entry.tx;
               if (esc_ff) begin
                  esc_in    = 1'b0;
                  do_push   = 1'b1;
                  push_d    = {1'b1, q_entry.data[rfd_pkg::BYTE_W-2:0]};
                  push_code = q_entry.escaped_code;
               end else if (q_entry.kind == rfd_pkg::ITEM_ESCAPE) begin
                  esc_in = 1'b1;
               end else begin
                  do_push = 1'b1;
               end
            end
         end

         // Deliver a data byte and check whether the frame is complete.
         if (do_push) begin
            pos         = count_in;
            pos9        = rfd_pkg::POS_W'(pos);
            check_short = short_in;
            if (pos == '0) begin
               start_in = push_code;
            end
            if (pos9 == rfd_pkg::HDR_CTRL_POS) begin
               short_in = rfd_pkg::is_short_form(push_d);
            end
            if (nres == 2'd0) begin
               r0 = rfd_pkg::make_data(push_d, pos9, echo_in);
            end else begin
               r1 = rfd_pkg::make_data(push_d, pos9, echo_in);
            end
            nres     = nres + 2'd1;
            cnt1     = {1'b0, pos} + 1'b1;
            count_in = cnt1[CW-1:0];

            if (!lk_in) begin
               unique case (start_in)
                  rfd_pkg::START_LONG: begin
                     if (pos9 == rfd_pkg::HDR_SHORT_LEN_POS && check_short) begin
                        exp_in = rfd_pkg::EXP_W'(push_d) + rfd_pkg::SHORT_LEN_BIAS;
                        lk_in  = 1'b1;
                     end else if (pos9 == rfd_pkg::HDR_LONG_LEN_POS && !check_short) begin
                        exp_in = rfd_pkg::EXP_W'(push_d) + rfd_pkg::LONG_LEN_BIAS;
                        lk_in  = 1'b1;
                     end
                  end
                  rfd_pkg::START_SHORT: begin
                     if (pos9 == rfd_pkg::HDR_FE_LEN_POS) begin
                        exp_in = rfd_pkg::EXP_W'(push_d);
                        lk_in  = 1'b1;
                     end
                  end
                  rfd_pkg::START_ACK: begin
                     end_now    = 1'b1;
                     end_status = rfd_pkg::STATUS_ACK;
                  end
                  rfd_pkg::START_OTHER: begin
                  end
                  default: begin
                  end
               endcase
            end

            if (!end_now) begin
               if (lk_in && (rfd_pkg::CMP_W'(cnt1) >= rfd_pkg::CMP_W'(exp_in))) begin
                  end_now = 1'b1;
               end else if (cnt1 >= MAX_COUNT) begin
                  end_now = 1'b1;
               end
            end

            if (end_now) begin
               r1    = rfd_pkg::make_end(end_status, echo_in);
               nres  = 2'd2;
               clear = 1'b1;
            end
         end

         // Closing a frame returns the state to its idle values.
         if (clear) begin
            in_frame_in = 1'b0;
            esc_in      = 1'b0;
            count_in    = '0;
            start_in    = rfd_pkg::START_OTHER;
            short_in    = 1'b1;
            exp_in      = '0;
            lk_in       = 1'b0;
            gap_in      = '0;
            echo_in     = 1'b0;
         end

         // Mark the final result of the item.
         if (nres == 2'd1) begin
            r0.last = 1'b1;
         end else if (nres == 2'd2) begin
            r1.last = 1'b1;
         end
      end
   end

   // Result slots: the second slot drains into the first before new work.
   always_comb begin
      av_in = av_ff;
      bv_in = bv_ff;
      a_in  = a_ff;
      b_in  = b_ff;
      if (bv_ff) begin
         if (taken) begin
            a_in  = b_ff;
            bv_in = 1'b0;
         end
      end else begin
         if (taken) begin
            av_in = 1'b0;
         end
         if (q_pop && nres != 2'd0) begin
            a_in  = r0;
            av_in = 1'b1;
            if (nres == 2'd2) begin
               b_in  = r1;
               bv_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         count_ff    <= '0;
         start_ff    <= rfd_pkg::START_OTHER;
         short_ff    <= 1'b1;
         exp_ff      <= '0;
         lk_ff       <= 1'b0;
         gap_ff      <= '0;
         echo_ff     <= 1'b0;
         av_ff       <= 1'b0;
         bv_ff       <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         count_ff    <= count_in;
         start_ff    <= start_in;
         short_ff    <= short_in;
         exp_ff      <= exp_in;
         lk_ff       <= lk_in;
         gap_ff      <= gap_in;
         echo_ff     <= echo_in;
         av_ff       <= av_in;
         bv_ff       <= bv_in;
      end
   end

   // Result payloads need no reset.
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

### design/rs485_frame_deframer.sv
// Frame receiver for an escaped, start-byte framed serial line.
// The req channel takes one item per accepted cycle: a line byte
// (req_cmd low, req_rx_byte) or one timer tick (req_cmd high), with
// req_own_transmit flagging bytes heard while the host drives the line.
// The rsp channel returns unescaped frame bytes with their position and
// an end marker with the cause when a frame closes; rsp_last marks the
// final result of each item. An item gives zero, one or two results.
// The gap timeout is written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, the block does not enforce this. The first result
// of an accepted item is registered in the queue and in slot a before it is
// valid. One item is taken every cycle as long as results are taken; an item
// with two results holds off the next item while slot b holds its second
// result, as the port carries one result a cycle. A two-entry queue separates
// the classifier from the frame logic, so a stalled receiver fills the queue
// and then raises req_stall; nothing is dropped. Reset empties the queue and
// result slots, closes any open frame and returns the gap timeout to 7 ticks.
module rs485_frame_deframer #(
   parameter int MAX_FRAME_BYTES = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [rfd_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                           req_own_transmit,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [rfd_pkg::BYTE_W-1:0]     rsp_data,
   output logic [rfd_pkg::POS_W-1:0]      rsp_position,
   output logic [1:0]                     rsp_frame_status,
   output logic                           rsp_echo,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [rfd_pkg::TICK_W-1:0]     csr_wr_data
);

   logic [rfd_pkg::TICK_W-1:0] timeout_ff, timeout_in;
   rfd_pkg::entry_type         front_entry;
   rfd_pkg::entry_type         q_entry;
   logic                       q_full;
   logic                       q_valid;
   logic                       q_pop;
   rfd_pkg::result_type        result;

   // Gap timeout register.
   assign timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= rfd_pkg::GAP_TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   rfd_front u_front (
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .req_own_transmit (req_own_transmit),
      .entry            (front_entry)
   );

   rfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   assign req_stall = q_full;

   rfd_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .gap_timeout (timeout_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (result)
   );

   // Result fields onto their ports.
   assign rsp_kind         = result.kind;
   assign rsp_data         = result.data;
   assign rsp_position     = result.position;
   assign rsp_frame_status = result.status;
   assign rsp_echo         = result.echo;
   assign rsp_last         = result.last;

endmodule
